[rtl/core/gos_pkg.sv]
// ----------------------------------------------------------------------------
// Glyph outline segmenter package
// Shared coordinate, item and result types and the tag and segment codes.
// ----------------------------------------------------------------------------
package gos_pkg;

    localparam int InW      = 24;
    localparam int CoordW   = 26;
    localparam int TagW     = 8;
    localparam int KindW    = 2;
    localparam int FrontQDepth = 2;
    localparam int OutQDepth   = 2;

    localparam logic [1:0] TAG_CONIC = 2'd0;
    localparam logic [1:0] TAG_ON    = 2'd1;
    localparam logic [1:0] TAG_CUBIC = 2'd2;

    localparam logic [KindW-1:0] KIND_LINE  = 2'd0;
    localparam logic [KindW-1:0] KIND_QUAD  = 2'd1;
    localparam logic [KindW-1:0] KIND_CUBIC = 2'd2;
    localparam logic [KindW-1:0] KIND_CLOSE = 2'd3;

    localparam logic [1:0] QUAD_LIMIT = 2'd3;

    typedef logic signed [CoordW-1:0] t_coord;

    typedef struct packed {
        t_coord x;
        t_coord y;
    } t_pt;

    typedef struct packed {
        t_pt        pt;
        logic [1:0] tag;
        logic       contour_end;
    } t_item;

    typedef struct packed {
        logic [KindW-1:0] kind;
        t_pt              start;
        t_pt              ctrl1;
        t_pt              ctrl2;
        t_pt              stop;
        logic             overflow;
        logic             last;
    } t_result;

endpackage

[rtl/core/glyph_outline_segmenter_core.sv]
// A point's results pass through the front queue, the back-end segment sequencer and the
// output queue; each result is held until the next one or the end of its point.
// The back-end segment sequencer works on one point at a time and takes a new point only
// once it is through with the last one; a full output queue can hold it.
// Reset: synchronous, active low; clears queues, list counts and sequencer.
// ----------------------------------------------------------------------------
// Glyph outline segmenter core
// Splits a stream of outline points into line, quadratic, cubic and
// contour-close segments in 1/128 pixel units.
// ----------------------------------------------------------------------------
module glyph_outline_segmenter_core #(
    parameter int LIST_DEPTH = 4
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              push,
    output logic                              full,
    input  logic [gos_pkg::InW-1:0]           i_point_x,
    input  logic [gos_pkg::InW-1:0]           i_point_y,
    input  logic [gos_pkg::TagW-1:0]          i_point_tag,
    input  logic                              i_contour_end,
    output logic                              empty,
    input  logic                              pop,
    output logic [gos_pkg::KindW-1:0]         o_segment_kind,
    output logic signed [gos_pkg::CoordW-1:0] o_start_x,
    output logic signed [gos_pkg::CoordW-1:0] o_start_y,
    output logic signed [gos_pkg::CoordW-1:0] o_ctrl1_x,
    output logic signed [gos_pkg::CoordW-1:0] o_ctrl1_y,
    output logic signed [gos_pkg::CoordW-1:0] o_ctrl2_x,
    output logic signed [gos_pkg::CoordW-1:0] o_ctrl2_y,
    output logic signed [gos_pkg::CoordW-1:0] o_end_x,
    output logic signed [gos_pkg::CoordW-1:0] o_end_y,
    output logic                              o_list_overflow,
    output logic                              o_last_result
);

    localparam int ResW = $bits(gos_pkg::t_result);

    gos_pkg::t_item   item;
    logic             item_vld;
    logic             item_take;
    gos_pkg::t_result res;
    logic             res_push;
    logic             res_full;
    logic [ResW-1:0]  out_q;
    gos_pkg::t_result out_res;

    gos_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (push),
        .o_full        (full),
        .i_point_x     (i_point_x),
        .i_point_y     (i_point_y),
        .i_point_tag   (i_point_tag),
        .i_contour_end (i_contour_end),
        .o_item        (item),
        .o_item_vld    (item_vld),
        .i_item_take   (item_take)
    );

    gos_back #(
        .LIST_DEPTH (LIST_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (item),
        .i_item_vld  (item_vld),
        .o_item_take (item_take),
        .o_res       (res),
        .o_res_push  (res_push),
        .i_res_full  (res_full)
    );

    gos_fifo #(
        .WIDTH (ResW),
        .DEPTH (gos_pkg::OutQDepth)
    ) u_out_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_data  (out_q),
        .o_empty (empty)
    );

    assign out_res         = gos_pkg::t_result'(out_q);
    assign o_segment_kind  = out_res.kind;
    assign o_start_x       = out_res.start.x;
    assign o_start_y       = out_res.start.y;
    assign o_ctrl1_x       = out_res.ctrl1.x;
    assign o_ctrl1_y       = out_res.ctrl1.y;
    assign o_ctrl2_x       = out_res.ctrl2.x;
    assign o_ctrl2_y       = out_res.ctrl2.y;
    assign o_end_x         = out_res.stop.x;
    assign o_end_y         = out_res.stop.y;
    assign o_list_overflow = out_res.overflow;
    assign o_last_result   = out_res.last;

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_push |-> !res_full)
        else $error("result written into a full output queue");

    a_close_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && (o_segment_kind == gos_pkg::KIND_CLOSE)) |-> o_last_result)
        else $error("contour close not marked as last result");

    a_ctrl2_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && (o_segment_kind != gos_pkg::KIND_CUBIC))
        |-> ((o_ctrl2_x == '0) && (o_ctrl2_y == '0)))
        else $error("second control point set on a non-cubic segment");

    a_take_only_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        item_take |-> item_vld)
        else $error("back end took a word from an empty front queue");

endmodule

[rtl/core/gos_fifo.sv]
// ----------------------------------------------------------------------------
// Glyph outline segmenter word queue
// Small register queue with push/full and pop/empty sides.
// ----------------------------------------------------------------------------
module gos_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr_ptr;
    logic [AW-1:0]    r_rd_ptr;
    logic [CW-1:0]    r_count;
    logic [AW-1:0]    n_wr_ptr;
    logic [AW-1:0]    n_rd_ptr;
    logic [CW-1:0]    n_count;
    logic             push_fire;
    logic             pop_fire;

    assign o_full    = (r_count == CW'(DEPTH));
    assign o_empty   = (r_count == '0);
    assign o_data    = r_mem[r_rd_ptr];
    assign push_fire = i_push && !o_full;
    assign pop_fire  = i_pop && !o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (push_fire) begin
            n_wr_ptr = (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + AW'(1);
        end
        if (pop_fire) begin
            n_rd_ptr = (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + AW'(1);
        end
        if (push_fire && !pop_fire) begin
            n_count = r_count + CW'(1);
        end else if (pop_fire && !push_fire) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_fire) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

[rtl/core/gos_front.sv]
// ----------------------------------------------------------------------------
// Glyph outline segmenter front end
// Converts 26.6 points to 1/128 pixel units with y negated, decodes the tag
// and queues the word for the segment sequencer.
// ----------------------------------------------------------------------------
module gos_front (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    output logic                       o_full,
    input  logic [gos_pkg::InW-1:0]    i_point_x,
    input  logic [gos_pkg::InW-1:0]    i_point_y,
    input  logic [gos_pkg::TagW-1:0]   i_point_tag,
    input  logic                       i_contour_end,
    output gos_pkg::t_item             o_item,
    output logic                       o_item_vld,
    input  logic                       i_item_take
);

    localparam int ItemW = $bits(gos_pkg::t_item);

    gos_pkg::t_item   item_in;
    logic [ItemW-1:0] item_q;
    logic             q_empty;
    logic [gos_pkg::CoordW-1:0] y_dbl;

    assign y_dbl = {i_point_y[gos_pkg::InW-1], i_point_y, 1'b0};

    always_comb begin
        item_in.pt.x        = gos_pkg::t_coord'({i_point_x[gos_pkg::InW-1], i_point_x, 1'b0});
        item_in.pt.y        = gos_pkg::t_coord'(~y_dbl + gos_pkg::CoordW'(1));
        item_in.tag         = i_point_tag[1:0];
        item_in.contour_end = i_contour_end;
    end

    gos_fifo #(
        .WIDTH (ItemW),
        .DEPTH (gos_pkg::FrontQDepth)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push),
        .i_data  (item_in),
        .o_full  (o_full),
        .i_pop   (i_item_take),
        .o_data  (item_q),
        .o_empty (q_empty)
    );

    assign o_item     = gos_pkg::t_item'(item_q);
    assign o_item_vld = !q_empty;

endmodule

[rtl/core/gos_back.sv]
// ----------------------------------------------------------------------------
// Glyph outline segmenter back end
// Keeps the on, conic and cubic point lists and steps through the segment
// checks for one word at a time, holding each result until the next one.
// ----------------------------------------------------------------------------
module gos_back #(
    parameter int LIST_DEPTH = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  gos_pkg::t_item    i_item,
    input  logic              i_item_vld,
    output logic              o_item_take,
    output gos_pkg::t_result  o_res,
    output logic              o_res_push,
    input  logic              i_res_full
);

    localparam int IdxW = $clog2(LIST_DEPTH);
    localparam int CntW = $clog2(LIST_DEPTH + 1);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_CUBIC = 3'd1;
    localparam logic [2:0] ST_MID   = 3'd2;
    localparam logic [2:0] ST_QUAD  = 3'd3;
    localparam logic [2:0] ST_LINE  = 3'd4;
    localparam logic [2:0] ST_CLOSE = 3'd5;
    localparam logic [2:0] ST_FLUSH = 3'd6;

    gos_pkg::t_pt     r_on    [LIST_DEPTH];
    gos_pkg::t_pt     r_conic [LIST_DEPTH];
    gos_pkg::t_pt     r_cub   [LIST_DEPTH];
    gos_pkg::t_pt     n_on    [LIST_DEPTH];
    gos_pkg::t_pt     n_conic [LIST_DEPTH];
    gos_pkg::t_pt     n_cub   [LIST_DEPTH];
    logic [CntW-1:0]  r_on_cnt, r_conic_cnt, r_cub_cnt;
    logic [CntW-1:0]  n_on_cnt, n_conic_cnt, n_cub_cnt;
    logic [2:0]       r_state, n_state;
    logic [1:0]       r_q, n_q;
    logic             r_ovf, n_ovf;
    logic             r_end, n_end;
    gos_pkg::t_result r_hold, n_hold;
    logic             r_hold_vld, n_hold_vld;

    gos_pkg::t_result res_new;
    gos_pkg::t_pt     mid;
    logic [gos_pkg::CoordW:0] sum_x, sum_y;
    logic             emit;
    logic             emit_ok;
    logic             flush_push;
    logic             cubic_cond, mid_cond, quad_cond, line_cond;

    assign sum_x = {r_conic[0].x[gos_pkg::CoordW-1], r_conic[0].x}
                 + {r_conic[1].x[gos_pkg::CoordW-1], r_conic[1].x};
    assign sum_y = {r_conic[0].y[gos_pkg::CoordW-1], r_conic[0].y}
                 + {r_conic[1].y[gos_pkg::CoordW-1], r_conic[1].y};
    assign mid.x = gos_pkg::t_coord'(sum_x[gos_pkg::CoordW:1]);
    assign mid.y = gos_pkg::t_coord'(sum_y[gos_pkg::CoordW:1]);

    assign cubic_cond = (r_cub_cnt == CntW'(2)) && (r_on_cnt == CntW'(2));
    assign mid_cond   = (r_conic_cnt == CntW'(2)) && (r_on_cnt < CntW'(2));
    assign quad_cond  = (r_q != gos_pkg::QUAD_LIMIT) && (r_conic_cnt != '0)
                      && (r_on_cnt >= CntW'(2));
    assign line_cond  = (r_on_cnt == CntW'(2)) && (r_conic_cnt == '0)
                      && (r_cub_cnt == '0);
    assign emit_ok    = !r_hold_vld || !i_res_full;

    always_comb begin
        n_state     = r_state;
        n_on        = r_on;
        n_conic     = r_conic;
        n_cub       = r_cub;
        n_on_cnt    = r_on_cnt;
        n_conic_cnt = r_conic_cnt;
        n_cub_cnt   = r_cub_cnt;
        n_q         = r_q;
        n_ovf       = r_ovf;
        n_end       = r_end;
        n_hold      = r_hold;
        n_hold_vld  = r_hold_vld;
        res_new     = '0;
        res_new.overflow = r_ovf;
        emit        = 1'b0;
        flush_push  = 1'b0;
        o_item_take = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                if (i_item_vld) begin
                    o_item_take = 1'b1;
                    n_end       = i_item.contour_end;
                    n_ovf       = 1'b0;
                    case (i_item.tag)
                        gos_pkg::TAG_ON: begin
                            if (r_on_cnt == CntW'(LIST_DEPTH)) begin
                                n_ovf = 1'b1;
                            end else begin
                                n_on[r_on_cnt[IdxW-1:0]] = i_item.pt;
                                n_on_cnt = r_on_cnt + CntW'(1);
                            end
                        end
                        gos_pkg::TAG_CONIC: begin
                            if (r_conic_cnt == CntW'(LIST_DEPTH)) begin
                                n_ovf = 1'b1;
                            end else begin
                                n_conic[r_conic_cnt[IdxW-1:0]] = i_item.pt;
                                n_conic_cnt = r_conic_cnt + CntW'(1);
                            end
                        end
                        gos_pkg::TAG_CUBIC: begin
                            if (r_cub_cnt == CntW'(LIST_DEPTH)) begin
                                n_ovf = 1'b1;
                            end else begin
                                n_cub[r_cub_cnt[IdxW-1:0]] = i_item.pt;
                                n_cub_cnt = r_cub_cnt + CntW'(1);
                            end
                        end
                        default: ;
                    endcase
                    n_state = ST_CUBIC;
                end
            end
            ST_CUBIC: begin
                if (cubic_cond) begin
                    if (emit_ok) begin
                        emit          = 1'b1;
                        res_new.kind  = gos_pkg::KIND_CUBIC;
                        res_new.start = r_on[0];
                        res_new.ctrl1 = r_cub[0];
                        res_new.ctrl2 = r_cub[1];
                        res_new.stop  = r_on[1];
                        n_cub_cnt     = '0;
                        for (int i = 0; i < LIST_DEPTH - 1; i++) begin
                            n_on[i] = r_on[i+1];
                        end
                        n_on_cnt = r_on_cnt - CntW'(1);
                        n_state  = ST_MID;
                    end
                end else begin
                    if (mid_cond) begin
                        n_on[r_on_cnt[IdxW-1:0]] = mid;
                        n_on_cnt = r_on_cnt + CntW'(1);
                    end
                    n_q     = '0;
                    n_state = ST_QUAD;
                end
            end
            ST_MID: begin
                if (mid_cond) begin
                    n_on[r_on_cnt[IdxW-1:0]] = mid;
                    n_on_cnt = r_on_cnt + CntW'(1);
                end
                n_q     = '0;
                n_state = ST_QUAD;
            end
            ST_QUAD: begin
                if (quad_cond) begin
                    if (emit_ok) begin
                        emit          = 1'b1;
                        res_new.kind  = gos_pkg::KIND_QUAD;
                        res_new.start = r_on[0];
                        res_new.ctrl1 = r_conic[0];
                        res_new.stop  = r_on[1];
                        for (int i = 0; i < LIST_DEPTH - 1; i++) begin
                            n_on[i]    = r_on[i+1];
                            n_conic[i] = r_conic[i+1];
                        end
                        n_on_cnt    = r_on_cnt - CntW'(1);
                        n_conic_cnt = r_conic_cnt - CntW'(1);
                        n_q         = r_q + 2'd1;
                    end
                end else begin
                    n_state = ST_LINE;
                end
            end
            ST_LINE: begin
                if (line_cond) begin
                    if (emit_ok) begin
                        emit          = 1'b1;
                        res_new.kind  = gos_pkg::KIND_LINE;
                        res_new.start = r_on[0];
                        res_new.stop  = r_on[1];
                        for (int i = 0; i < LIST_DEPTH - 1; i++) begin
                            n_on[i] = r_on[i+1];
                        end
                        n_on_cnt = r_on_cnt - CntW'(1);
                        n_state  = ST_CLOSE;
                    end
                end else begin
                    n_state = ST_CLOSE;
                end
            end
            ST_CLOSE: begin
                if (r_end) begin
                    if (emit_ok) begin
                        emit         = 1'b1;
                        res_new.kind = gos_pkg::KIND_CLOSE;
                        n_on_cnt     = '0;
                        n_conic_cnt  = '0;
                        n_cub_cnt    = '0;
                        n_state      = ST_FLUSH;
                    end
                end else begin
                    n_state = ST_FLUSH;
                end
            end
            ST_FLUSH: begin
                if (!r_hold_vld) begin
                    n_state = ST_IDLE;
                end else if (!i_res_full) begin
                    flush_push = 1'b1;
                    n_hold_vld = 1'b0;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        if (emit) begin
            n_hold     = res_new;
            n_hold_vld = 1'b1;
        end
    end

    // Release the held word on the next emit or, marked last, at the end
    always_comb begin
        o_res      = r_hold;
        o_res.last = (r_state == ST_FLUSH);
        o_res_push = (emit && r_hold_vld) || flush_push;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_on_cnt    <= '0;
            r_conic_cnt <= '0;
            r_cub_cnt   <= '0;
            r_hold_vld  <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_on_cnt    <= n_on_cnt;
            r_conic_cnt <= n_conic_cnt;
            r_cub_cnt   <= n_cub_cnt;
            r_hold_vld  <= n_hold_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_on    <= n_on;
        r_conic <= n_conic;
        r_cub   <= n_cub;
        r_q     <= n_q;
        r_ovf   <= n_ovf;
        r_end   <= n_end;
        r_hold  <= n_hold;
    end

endmodule

[tb/glyph_outline_segmenter_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Glyph outline segmenter checker
// Watches the point and segment queues of the segmenter core. It keeps its
// own on, conic and cubic point lists, works out the segment words that each
// accepted point releases, and compares every popped word field by field
// with the oldest one still owed.
// ----------------------------------------------------------------------------
module glyph_outline_segmenter_checker #(
    parameter int LIST_DEPTH = 4
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_push,
    input  logic                              i_full,
    input  logic [gos_pkg::InW-1:0]           i_point_x,
    input  logic [gos_pkg::InW-1:0]           i_point_y,
    input  logic [gos_pkg::TagW-1:0]          i_point_tag,
    input  logic                              i_contour_end,
    input  logic                              i_empty,
    input  logic                              i_pop,
    input  logic [gos_pkg::KindW-1:0]         i_segment_kind,
    input  logic signed [gos_pkg::CoordW-1:0] i_start_x,
    input  logic signed [gos_pkg::CoordW-1:0] i_start_y,
    input  logic signed [gos_pkg::CoordW-1:0] i_ctrl1_x,
    input  logic signed [gos_pkg::CoordW-1:0] i_ctrl1_y,
    input  logic signed [gos_pkg::CoordW-1:0] i_ctrl2_x,
    input  logic signed [gos_pkg::CoordW-1:0] i_ctrl2_y,
    input  logic signed [gos_pkg::CoordW-1:0] i_end_x,
    input  logic signed [gos_pkg::CoordW-1:0] i_end_y,
    input  logic                              i_list_overflow,
    input  logic                              i_last_result,
    output int                                o_mismatches,
    output int                                o_pending,
    output int                                o_words,
    output int                                o_overflow_words
);
    import gos_pkg::*;

    localparam int LIST_ON    = 0;
    localparam int LIST_CONIC = 1;
    localparam int LIST_CUBIC = 2;
    localparam int MAX_PRINTS = 40;

    t_pt     list_pts[3][LIST_DEPTH];
    int      list_cnt[3];
    t_result step_segs[8];
    int      step_n;
    t_result segment_backlog[$];

    function automatic bit add_point(int id, t_pt p);
        if (list_cnt[id] >= LIST_DEPTH)
            return 1'b0;
        list_pts[id][list_cnt[id]] = p;
        list_cnt[id]++;
        return 1'b1;
    endfunction

    function automatic void drop_front(int id);
        int k;
        if (list_cnt[id] == 0)
            return;
        for (k = 0; k + 1 < list_cnt[id]; k++)
            list_pts[id][k] = list_pts[id][k + 1];
        list_cnt[id]--;
    endfunction

    task automatic stage_segment(input logic [KindW-1:0] kind, input t_pt s, input t_pt c1,
                                 input t_pt c2, input t_pt e, input logic ovf);
        t_result seg;
        seg.kind     = kind;
        seg.start    = s;
        seg.ctrl1    = c1;
        seg.ctrl2    = c2;
        seg.stop     = e;
        seg.overflow = ovf;
        seg.last     = 1'b0;
        step_segs[step_n] = seg;
        step_n++;
    endtask

    task automatic segment_point(input logic [InW-1:0] xin, input logic [InW-1:0] yin,
                                 input logic [1:0] tag, input logic ends_contour);
        t_pt     p;
        t_pt     mid;
        t_pt     origin;
        t_result seg;
        logic    ovf;
        int      xi;
        int      yi;
        int      q;
        int      k;
        origin = '0;
        ovf    = 1'b0;
        step_n = 0;
        xi     = $signed(xin);
        yi     = $signed(yin);
        p.x    = t_coord'(2 * xi);
        p.y    = t_coord'(-2 * yi);

        case (tag)
            TAG_ON:    ovf = !add_point(LIST_ON, p);
            TAG_CONIC: ovf = !add_point(LIST_CONIC, p);
            TAG_CUBIC: ovf = !add_point(LIST_CUBIC, p);
            default:   ovf = 1'b0;
        endcase

        if (list_cnt[LIST_CUBIC] == 2 && list_cnt[LIST_ON] == 2) begin
            stage_segment(KIND_CUBIC, list_pts[LIST_ON][0], list_pts[LIST_CUBIC][0],
                          list_pts[LIST_CUBIC][1], list_pts[LIST_ON][1], ovf);
            list_cnt[LIST_CUBIC] = 0;
            drop_front(LIST_ON);
        end

        // add the implied on point between two pending conic controls
        if (list_cnt[LIST_CONIC] == 2 && list_cnt[LIST_ON] < 2) begin
            mid.x = t_coord'((int'(list_pts[LIST_CONIC][0].x)
                              + int'(list_pts[LIST_CONIC][1].x)) / 2);
            mid.y = t_coord'((int'(list_pts[LIST_CONIC][0].y)
                              + int'(list_pts[LIST_CONIC][1].y)) / 2);
            void'(add_point(LIST_ON, mid));
        end

        for (q = 0; q < int'(QUAD_LIMIT) && list_cnt[LIST_CONIC] >= 1
                    && list_cnt[LIST_ON] >= 2; q++) begin
            stage_segment(KIND_QUAD, list_pts[LIST_ON][0], list_pts[LIST_CONIC][0],
                          origin, list_pts[LIST_ON][1], ovf);
            drop_front(LIST_CONIC);
            drop_front(LIST_ON);
        end

        if (list_cnt[LIST_ON] == 2 && list_cnt[LIST_CONIC] == 0
                && list_cnt[LIST_CUBIC] == 0) begin
            stage_segment(KIND_LINE, list_pts[LIST_ON][0], origin, origin,
                          list_pts[LIST_ON][1], ovf);
            drop_front(LIST_ON);
        end

        if (ends_contour) begin
            list_cnt[LIST_ON]    = 0;
            list_cnt[LIST_CONIC] = 0;
            list_cnt[LIST_CUBIC] = 0;
            stage_segment(KIND_CLOSE, origin, origin, origin, origin, ovf);
        end

        for (k = 0; k < step_n; k++) begin
            seg      = step_segs[k];
            seg.last = (k == step_n - 1);
            segment_backlog.insert(segment_backlog.size(), seg);
        end
    endtask

    task automatic report_mismatch(input string what);
        if (o_mismatches < MAX_PRINTS)
            $display("%0t: segment word %0d: %s", $time, o_words, what);
        o_mismatches++;
    endtask

    task automatic check_coord(input string name, input t_coord got, input t_coord want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0d, want %0d", name, got, want));
    endtask

    task automatic check_word();
        t_result want;
        if (segment_backlog.size() == 0) begin
            report_mismatch("popped with no segment owed");
        end else begin
            want = segment_backlog.pop_front();
            if (i_segment_kind !== want.kind)
                report_mismatch($sformatf("kind got %0d, want %0d", i_segment_kind, want.kind));
            check_coord("start_x", i_start_x, want.start.x);
            check_coord("start_y", i_start_y, want.start.y);
            check_coord("ctrl1_x", i_ctrl1_x, want.ctrl1.x);
            check_coord("ctrl1_y", i_ctrl1_y, want.ctrl1.y);
            check_coord("ctrl2_x", i_ctrl2_x, want.ctrl2.x);
            check_coord("ctrl2_y", i_ctrl2_y, want.ctrl2.y);
            check_coord("end_x", i_end_x, want.stop.x);
            check_coord("end_y", i_end_y, want.stop.y);
            if (i_list_overflow !== want.overflow)
                report_mismatch($sformatf("list_overflow got %b, want %b",
                                          i_list_overflow, want.overflow));
            if (i_last_result !== want.last)
                report_mismatch($sformatf("last_result got %b, want %b",
                                          i_last_result, want.last));
            if (want.overflow)
                o_overflow_words++;
        end
        o_words++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            list_cnt[LIST_ON]    = 0;
            list_cnt[LIST_CONIC] = 0;
            list_cnt[LIST_CUBIC] = 0;
            segment_backlog.delete();
            o_mismatches         = 0;
            o_words              = 0;
            o_overflow_words     = 0;
        end else begin
            if (i_pop && !i_empty)
                check_word();
            if (i_push && !i_full)
                segment_point(i_point_x, i_point_y, i_point_tag[1:0], i_contour_end);
        end
        o_pending = segment_backlog.size();
    end

endmodule

[tb/glyph_outline_segmenter_core_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Glyph outline segmenter core testbench
// Feeds outline points through the point queue: a run of corner cases, then
// random contours under three idling mixes on the push and pop sides, with a
// full drain between mixes. A side checker predicts and compares every
// segment word; this module drives stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module glyph_outline_segmenter_core_tb;
    import gos_pkg::*;

    localparam int         LIST_DEPTH   = 4;
    localparam logic [1:0] TAG_SKIP     = 2'd3;
    localparam int         STALL_LIMIT  = 1000;
    localparam int         DRAIN_CYCLES = 40;
    localparam int         PHASE_POINTS = 117;
    localparam logic [InW-1:0] COORD_MAX = {1'b0, {(InW-1){1'b1}}};
    localparam logic [InW-1:0] COORD_MIN = {1'b1, {(InW-1){1'b0}}};

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  push;
    logic                  full;
    logic [InW-1:0]        i_point_x;
    logic [InW-1:0]        i_point_y;
    logic [TagW-1:0]       i_point_tag;
    logic                  i_contour_end;
    logic                  empty;
    logic                  pop = 1'b0;
    logic [KindW-1:0]      o_segment_kind;
    logic signed [CoordW-1:0] o_start_x;
    logic signed [CoordW-1:0] o_start_y;
    logic signed [CoordW-1:0] o_ctrl1_x;
    logic signed [CoordW-1:0] o_ctrl1_y;
    logic signed [CoordW-1:0] o_ctrl2_x;
    logic signed [CoordW-1:0] o_ctrl2_y;
    logic signed [CoordW-1:0] o_end_x;
    logic signed [CoordW-1:0] o_end_y;
    logic                  o_list_overflow;
    logic                  o_last_result;

    int mismatches;
    int pending;
    int words;
    int overflow_words;
    int points_sent = 0;
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int stall_cycles = 0;

    glyph_outline_segmenter_core #(
        .LIST_DEPTH(LIST_DEPTH)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_point_x      (i_point_x),
        .i_point_y      (i_point_y),
        .i_point_tag    (i_point_tag),
        .i_contour_end  (i_contour_end),
        .empty          (empty),
        .pop            (pop),
        .o_segment_kind (o_segment_kind),
        .o_start_x      (o_start_x),
        .o_start_y      (o_start_y),
        .o_ctrl1_x      (o_ctrl1_x),
        .o_ctrl1_y      (o_ctrl1_y),
        .o_ctrl2_x      (o_ctrl2_x),
        .o_ctrl2_y      (o_ctrl2_y),
        .o_end_x        (o_end_x),
        .o_end_y        (o_end_y),
        .o_list_overflow(o_list_overflow),
        .o_last_result  (o_last_result)
    );

    glyph_outline_segmenter_checker #(
        .LIST_DEPTH(LIST_DEPTH)
    ) u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_push          (push),
        .i_full          (full),
        .i_point_x       (i_point_x),
        .i_point_y       (i_point_y),
        .i_point_tag     (i_point_tag),
        .i_contour_end   (i_contour_end),
        .i_empty         (empty),
        .i_pop           (pop),
        .i_segment_kind  (o_segment_kind),
        .i_start_x       (o_start_x),
        .i_start_y       (o_start_y),
        .i_ctrl1_x       (o_ctrl1_x),
        .i_ctrl1_y       (o_ctrl1_y),
        .i_ctrl2_x       (o_ctrl2_x),
        .i_ctrl2_y       (o_ctrl2_y),
        .i_end_x         (o_end_x),
        .i_end_y         (o_end_y),
        .i_list_overflow (o_list_overflow),
        .i_last_result   (o_last_result),
        .o_mismatches    (mismatches),
        .o_pending       (pending),
        .o_words         (words),
        .o_overflow_words(overflow_words)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    always @(negedge i_clk) begin
        pop <= ($urandom_range(99) >= rx_idle_pct);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (push && !full) || (pop && !empty)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("No handshake for %0d cycles, %0d segment words still owed",
                     STALL_LIMIT, pending);
            $display("== FAIL ==");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    function automatic logic [InW-1:0] pick_coord();
        logic [31:0] bits;
        bits = $urandom();
        case ($urandom_range(9))
            0:       return COORD_MAX;
            1:       return COORD_MIN;
            2:       return '0;
            3:       return '1;
            default: return bits[InW-1:0];
        endcase
    endfunction

    // hold push low for random idle cycles, then present the point until taken
    task automatic send_point(input logic [InW-1:0] x, input logic [InW-1:0] y,
                              input logic [TagW-1:0] tag, input logic ends_contour);
        while ($urandom_range(99) < tx_idle_pct) begin
            push <= 1'b0;
            @(negedge i_clk);
        end
        push          <= 1'b1;
        i_point_x     <= x;
        i_point_y     <= y;
        i_point_tag   <= tag;
        i_contour_end <= ends_contour;
        @(posedge i_clk);
        while (full)
            @(posedge i_clk);
        @(negedge i_clk);
        points_sent++;
    endtask

    initial begin
        int          phase;
        int          target;
        int          len;
        int          k;
        int          r;
        bit          ragged;
        logic        ends_contour;
        logic [1:0]  kind;
        logic [31:0] bits;

        i_rst_n       = 1'b0;
        push          = 1'b0;
        i_point_x     = '0;
        i_point_y     = '0;
        i_point_tag   = '0;
        i_contour_end = 1'b0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (phase = 0; phase < 3; phase++) begin
            tx_idle_pct = (phase == 0) ? 11 : (phase == 1) ? 48 : 0;
            rx_idle_pct = (phase == 0) ? 48 : (phase == 1) ? 11 : 0;

            if (phase == 0) begin
                // lines between coordinate extremes
                send_point(COORD_MIN, COORD_MAX, {6'h00, TAG_ON}, 1'b0);
                send_point(COORD_MAX, COORD_MIN, {6'h3F, TAG_ON}, 1'b0);
                send_point('0, '0, {6'h20, TAG_ON}, 1'b1);
                // quadratic, then a close on an ignored tag
                send_point(24'hFFFFFF, 24'h000001, {6'h01, TAG_ON}, 1'b0);
                send_point(24'h123456, 24'hABCDEF, {6'h00, TAG_CONIC}, 1'b0);
                send_point(24'h000040, 24'hFFFFC0, {6'h10, TAG_ON}, 1'b0);
                send_point(24'h555555, 24'hAAAAAA, {6'h00, TAG_SKIP}, 1'b1);
                // cubic closed on its end point
                send_point(COORD_MAX, COORD_MAX, {6'h00, TAG_ON}, 1'b0);
                send_point(COORD_MIN, COORD_MIN, {6'h00, TAG_CUBIC}, 1'b0);
                send_point(24'h000100, 24'hFFFF00, {6'h3F, TAG_CUBIC}, 1'b0);
                send_point(COORD_MIN, '0, {6'h00, TAG_ON}, 1'b1);
                // implied midpoint of two conics at the y extreme
                send_point(COORD_MAX, COORD_MIN, {6'h00, TAG_CONIC}, 1'b0);
                send_point(24'h7FFFFE, COORD_MIN, {6'h3F, TAG_CONIC}, 1'b0);
                send_point(24'h000002, 24'h000003, {6'h00, TAG_ON}, 1'b0);
                send_point(24'h2AAAAA, 24'hD55555, {6'h3F, TAG_SKIP}, 1'b1);
                // overflow the cubic list, closing on the dropped point
                for (k = 0; k < LIST_DEPTH + 1; k++)
                    send_point(pick_coord(), pick_coord(), {6'(k), TAG_CUBIC},
                               k == LIST_DEPTH);
                send_point(24'hFFFFFE, 24'h000100, {6'h00, TAG_CONIC}, 1'b1);
                send_point(COORD_MAX, COORD_MIN, {6'h00, TAG_ON}, 1'b1);
            end

            target = points_sent + PHASE_POINTS;
            while (points_sent < target) begin
                ragged = ($urandom_range(6) == 0);
                len    = ragged ? $urandom_range(10, 1) : $urandom_range(8, 2);
                for (k = 0; k < len; k++) begin
                    r = $urandom_range(19);
                    if (k == 0 && !ragged)
                        kind = TAG_ON;
                    else if (r < 9)
                        kind = TAG_ON;
                    else if (r < 14)
                        kind = TAG_CONIC;
                    else if (r < 18)
                        kind = TAG_CUBIC;
                    else
                        kind = TAG_SKIP;
                    bits         = $urandom();
                    ends_contour = ragged ? ($urandom_range(3) == 0) : (k == len - 1);
                    send_point(pick_coord(), pick_coord(), {bits[7:2], kind}, ends_contour);
                end
            end

            // hold off until every owed segment word has been popped
            push <= 1'b0;
            while (pending != 0)
                @(negedge i_clk);
        end

        repeat (DRAIN_CYCLES) @(negedge i_clk);

        $display("Sent %0d outline points: corner cases, then random contours", points_sent);
        $display("under three idling mixes; %0d segment words checked, %0d with list overflow",
                 words, overflow_words);
        if (pending != 0)
            $display("%0d segment words never arrived", pending);
        if (mismatches == 0 && pending == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
